/* hdl/dhse_pkg.sv */
// ----------------------------------------------------------------------------
// dhse_pkg
// Types, character codes and helper functions shared by the Digest header
// SHA-256 extractor.
// ----------------------------------------------------------------------------
package dhse_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // Accepted algorithm name lengths and the name length saturation value
    localparam logic [3:0] LEN_DASHED = 4'd7;
    localparam logic [3:0] LEN_PLAIN  = 4'd6;
    localparam logic [3:0] LEN_SAT    = 4'd8;

    // Parser phase
    typedef enum logic [2:0] {
        PH_SKIP  = 3'b001,
        PH_NAME  = 3'b010,
        PH_VALUE = 3'b100
    } t_phase;

    // Input item
    typedef struct packed {
        logic [7:0] ch;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic       found;
        logic [7:0] hex_char;
        logic [5:0] char_index;
        logic       last;
    } t_out_item;

    // Parser to emitter: start a result burst
    typedef struct packed {
        logic start;
        logic found;
    } t_emit_cmd;

    // "sha-256", one character per position
    function automatic logic [7:0] dashed_at(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h73; // s
            3'd1:    c = 8'h68; // h
            3'd2:    c = 8'h61; // a
            3'd3:    c = 8'h2D; // -
            3'd4:    c = 8'h32; // 2
            3'd5:    c = 8'h35; // 5
            3'd6:    c = 8'h36; // 6
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    // "sha256", one character per position
    function automatic logic [7:0] plain_at(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h73; // s
            3'd1:    c = 8'h68; // h
            3'd2:    c = 8'h61; // a
            3'd3:    c = 8'h32; // 2
            3'd4:    c = 8'h35; // 5
            3'd5:    c = 8'h36; // 6
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    // Full A-Z fold, used on algorithm names
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            r = c + CASE_OFS;
        end
        return r;
    endfunction

    // A-F fold only, used on digest characters
    function automatic logic [7:0] fold_hex(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UP_A && c <= CH_UP_F) begin
            r = c + CASE_OFS;
        end
        return r;
    endfunction

endpackage

/* hdl/dhse_stream_if.sv */
// ----------------------------------------------------------------------------
// dhse_stream_if
// Valid/ready stream channel; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface dhse_stream_if #(
    parameter type T = logic [7:0]
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/dhse_ram.sv */
// ----------------------------------------------------------------------------
// dhse_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module dhse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/dhse_parser.sv */
// ----------------------------------------------------------------------------
// dhse_parser
// Input register and header parser: tracks the entry being scanned, writes
// value characters into the digest buffer and starts a result burst at the
// terminator.
// ----------------------------------------------------------------------------
module dhse_parser
    import dhse_pkg::*;
#(
    parameter int DIGEST_CHARS = 64,
    localparam int AW = $clog2(DIGEST_CHARS),
    localparam int VW = $clog2(DIGEST_CHARS + 2)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dhse_stream_if.sink   i_in,
    input  logic          i_busy,
    output t_emit_cmd     o_cmd,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [7:0]    o_wdata
);
    localparam logic [VW-1:0] VLEN_FULL = VW'(DIGEST_CHARS);

    // Input register
    logic       r_valid;
    logic [7:0] r_ch;
    logic       adv;

    // Parse state
    t_phase        r_phase, n_phase;
    logic [3:0]    r_nlen, n_nlen;
    logic          r_md, n_md;
    logic          r_mp, n_mp;
    logic [VW-1:0] r_vlen, n_vlen;
    logic          r_found, n_found;

    // Working copies after an entry opens on a non-separator
    t_phase     eff_phase;
    logic [3:0] eff_nlen;
    logic       eff_md;
    logic       eff_mp;
    logic [7:0] lc;
    logic       is_sep;
    logic       fin_hit;

    assign adv        = r_valid && !i_busy;
    assign i_in.ready = !r_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_ch <= i_in.data.ch;
        end
    end

    // Next parse state for the registered character
    always_comb begin
        n_phase = r_phase;
        n_nlen  = r_nlen;
        n_md    = r_md;
        n_mp    = r_mp;
        n_vlen  = r_vlen;
        n_found = r_found;
        o_cmd   = '0;
        o_we    = 1'b0;
        o_waddr = r_vlen[AW-1:0];
        o_wdata = fold_hex(r_ch);
        lc      = to_lower(r_ch);
        is_sep  = (r_ch == CH_SPACE) || (r_ch == CH_TAB) || (r_ch == CH_COMMA);
        fin_hit = r_md && (r_vlen == VLEN_FULL);

        eff_phase = r_phase;
        eff_nlen  = r_nlen;
        eff_md    = r_md;
        eff_mp    = r_mp;
        if (r_phase == PH_SKIP && !is_sep) begin
            eff_phase = PH_NAME;
            eff_nlen  = '0;
            eff_md    = 1'b1;
            eff_mp    = 1'b1;
        end

        if (adv) begin
            if (r_ch == CH_NUL) begin
                // Terminator: judge an open value, start the burst, clear all
                o_cmd.start = 1'b1;
                o_cmd.found = r_found || (r_phase == PH_VALUE && fin_hit);
                n_phase     = PH_SKIP;
                n_nlen      = '0;
                n_md        = 1'b1;
                n_mp        = 1'b1;
                n_vlen      = '0;
                n_found     = 1'b0;
            end else if (!r_found) begin
                n_phase = eff_phase;
                n_nlen  = eff_nlen;
                n_md    = eff_md;
                n_mp    = eff_mp;
                unique case (eff_phase)
                    PH_SKIP: begin
                        // separator, nothing to do
                    end
                    PH_NAME: begin
                        if (r_ch == CH_EQ) begin
                            n_md    = (eff_nlen == LEN_DASHED && eff_md) ||
                                      (eff_nlen == LEN_PLAIN && eff_mp);
                            n_mp    = n_md;
                            n_vlen  = '0;
                            n_phase = PH_VALUE;
                        end else if (r_ch == CH_COMMA) begin
                            // entry without a value is dropped
                            n_phase = PH_SKIP;
                        end else begin
                            if (eff_nlen >= LEN_DASHED || lc != dashed_at(eff_nlen[2:0])) begin
                                n_md = 1'b0;
                            end
                            if (eff_nlen >= LEN_PLAIN || lc != plain_at(eff_nlen[2:0])) begin
                                n_mp = 1'b0;
                            end
                            if (eff_nlen < LEN_SAT) begin
                                n_nlen = eff_nlen + 4'd1;
                            end
                        end
                    end
                    PH_VALUE: begin
                        if (r_ch == CH_COMMA) begin
                            n_found = fin_hit;
                            n_phase = PH_SKIP;
                        end else begin
                            o_we = (r_vlen < VLEN_FULL);
                            if (r_vlen <= VLEN_FULL) begin
                                n_vlen = r_vlen + VW'(1);
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_SKIP;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_nlen  <= '0;
            r_md    <= 1'b1;
            r_mp    <= 1'b1;
            r_vlen  <= '0;
            r_found <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_nlen  <= n_nlen;
            r_md    <= n_md;
            r_mp    <= n_mp;
            r_vlen  <= n_vlen;
            r_found <= n_found;
        end
    end

    // A burst only starts from a terminator that is being processed
    a_start_on_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |-> (adv && r_ch == CH_NUL))
        else $error("burst started without a terminator");

    // No buffer write while a burst reads the buffer
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_busy |-> !o_we)
        else $error("buffer written during result burst");

    // A kept digest freezes the buffer write pointer
    a_found_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && !(adv && r_ch == CH_NUL)) |=> $stable(r_vlen))
        else $error("value length moved after a match");
endmodule

/* hdl/dhse_emitter.sv */
// ----------------------------------------------------------------------------
// dhse_emitter
// Result burst: walks the digest buffer, one read per cycle while the output
// is not stalled, through a read stage and the output register.
// ----------------------------------------------------------------------------
module dhse_emitter
    import dhse_pkg::*;
#(
    parameter int DIGEST_CHARS = 64,
    localparam int AW = $clog2(DIGEST_CHARS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_emit_cmd     i_cmd,
    output logic          o_busy,
    output logic          o_re,
    output logic [AW-1:0] o_raddr,
    input  logic [7:0]    i_rdata,
    dhse_stream_if.source o_out
);
    localparam logic [AW-1:0] LAST_IDX = AW'(DIGEST_CHARS - 1);

    // Burst control
    logic          r_busy;
    logic          r_mode_found;
    logic [AW-1:0] r_cnt;

    // Read stage (data sits in the RAM read register)
    logic          r_a_valid;
    logic          r_a_found;
    logic          r_a_last;
    logic [AW-1:0] r_a_idx;

    // Output register
    logic          r_o_valid;
    t_out_item     r_o;

    logic b_ready;
    logic a_adv;
    logic a_ready;
    logic issue;
    logic issue_last;

    assign b_ready    = !r_o_valid || o_out.ready;
    assign a_adv      = r_a_valid && b_ready;
    assign a_ready    = !r_a_valid || a_adv;
    assign issue      = r_busy && a_ready;
    assign issue_last = !r_mode_found || (r_cnt == LAST_IDX);

    assign o_busy  = r_busy;
    assign o_re    = issue;
    assign o_raddr = r_cnt;

    // Burst counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
        end else if (issue && issue_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cnt        <= '0;
            r_mode_found <= i_cmd.found;
        end else if (issue) begin
            r_cnt <= r_cnt + AW'(1);
        end
    end

    // Read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (issue) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_a_found <= r_mode_found;
            r_a_last  <= issue_last;
            r_a_idx   <= r_cnt;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (b_ready) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_o.found      <= r_a_found;
            r_o.hex_char   <= r_a_found ? i_rdata : CH_NUL;
            r_o.char_index <= r_a_found ? 6'(r_a_idx) : 6'd0;
            r_o.last       <= r_a_last;
        end
    end

    assign o_out.valid = r_o_valid;
    assign o_out.data  = r_o;

    // A new burst never arrives over a running one
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> !r_busy)
        else $error("burst start while busy");

    // Issuing the final read ends the burst
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && issue_last && !i_cmd.start) |=> !r_busy)
        else $error("burst did not end after its final read");

    // A not-found result is a single zero item marked last
    a_notfound_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o.found) |-> (r_o.last && r_o.hex_char == CH_NUL))
        else $error("malformed not-found result");
endmodule

/* hdl/digest_header_sha256_extract.sv */
// Path: the parser works on the character in the input register; a terminator
//   starts a burst that passes through the read stage and the output register.
// Throughput: one header character per cycle while no burst runs. A terminator
//   holds the input for its burst: with a digest, the buffer's single read port
//   streams one result per cycle unless the output stalls; without one, a single not-found item.
// Reset: synchronous, active low; clears the parser, burst and valid flags.
// ----------------------------------------------------------------------------
// digest_header_sha256_extract
// Scans a Digest header one character per item and returns the first
// sha-256 / sha256 value of DIGEST_CHARS characters, or a not-found item.
// ----------------------------------------------------------------------------
module digest_header_sha256_extract
    import dhse_pkg::*;
#(
    parameter int DIGEST_CHARS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dhse_stream_if.sink   i_in,
    dhse_stream_if.source o_out
);
    localparam int AW = $clog2(DIGEST_CHARS);

    t_emit_cmd     cmd;
    logic          busy;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;

    dhse_parser #(
        .DIGEST_CHARS (DIGEST_CHARS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_busy  (busy),
        .o_cmd   (cmd),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata)
    );

    // Digest buffer
    dhse_ram #(
        .WIDTH (8),
        .DEPTH (DIGEST_CHARS)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    dhse_emitter #(
        .DIGEST_CHARS (DIGEST_CHARS)
    ) u_emitter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_busy  (busy),
        .o_re    (re),
        .o_raddr (raddr),
        .i_rdata (rdata),
        .o_out   (o_out)
    );
endmodule
